FILE: design/fpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_pkg: shared types and constants
// Opcodes, register indexes, divider sizing and the command beat that passes
// from the front end to the divider back end.
// ----------------------------------------------------------------------------
package fpt_pkg;

	localparam int OPCODE_W    = 2;
	localparam int PERIOD_W    = 16;
	localparam int RPM_W       = 15;
	localparam int CMP_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int STALE_W     = 8;
	localparam int PWM_CNT_W   = 7;

	localparam logic [OPCODE_W-1:0] OP_CAPTURE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_POLL    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POWER_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_REQUEST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT  = 2'd2;

	localparam logic [STALE_W-1:0]   STALE_LIMIT_RESET = 8'd6;
	localparam logic [STALE_W-1:0]   STALE_SAT         = 8'hFF;
	localparam logic [CFG_DATA_W-1:0] DUTY_MAX         = 8'd100;
	localparam logic [PWM_CNT_W-1:0] PWM_LAST          = 7'd99;

	localparam int NUM_W = 25;
	localparam logic [NUM_W-1:0]    RPM_NUMERATOR  = 25'd30000000;
	localparam logic [PERIOD_W-1:0] RPM_MIN_PERIOD = 16'd1500;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

	typedef struct packed {
		logic                do_div;
		logic [PERIOD_W-1:0] period;
		logic                stale_timeout;
		logic                pwm_level;
		logic [CMP_W-1:0]    compare_value;
	} cmd_t;

	typedef struct packed {
		logic                  power_enable;
		logic [CFG_DATA_W-1:0] duty_request;
		logic [STALE_W-1:0]    stale_limit;
	} cfg_t;

endpackage
`default_nettype wire

FILE: design/fpt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_front: item decode and monitor state
// Holds tach period, freshness, stale count and PWM counter; turns each beat
// into a command for the back end.
// ----------------------------------------------------------------------------
module fpt_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              accept,
	input  wire [fpt_pkg::OPCODE_W-1:0]      opcode,
	input  wire [fpt_pkg::PERIOD_W-1:0]      capture_period,
	input  fpt_pkg::cfg_t                    cfg,
	output fpt_pkg::cmd_t                    cmd
);
	import fpt_pkg::*;

	logic [PERIOD_W-1:0]  period_q;
	logic                 fresh_q;
	logic [STALE_W-1:0]   stale_q;
	logic [PWM_CNT_W-1:0] pwm_cnt_q;

	logic [STALE_W-1:0]   stale_inc;
	logic                 timed_out;
	logic [PERIOD_W-1:0]  period_use;
	logic [PWM_CNT_W-1:0] pwm_cnt_next;
	logic [CFG_DATA_W-1:0] duty_clamped;
	logic [CMP_W-1:0]     cmp;

	assign stale_inc = (stale_q == STALE_SAT) ? stale_q : stale_q + 1'b1;
	assign timed_out = !fresh_q && (stale_inc > cfg.stale_limit);
	assign period_use = timed_out ? '0 : period_q;
	assign duty_clamped = (cfg.duty_request > DUTY_MAX) ? DUTY_MAX : cfg.duty_request;
	assign cmp = cfg.power_enable ? duty_clamped[CMP_W-1:0] : '0;

	always_comb begin
		pwm_cnt_next = pwm_cnt_q;
		if (opcode == OP_TICK) begin
			pwm_cnt_next = (pwm_cnt_q == PWM_LAST) ? '0 : pwm_cnt_q + 1'b1;
		end
	end

	always_comb begin
		cmd.do_div        = (opcode == OP_POLL) && !timed_out
		                    && (period_use >= RPM_MIN_PERIOD);
		cmd.period        = period_use;
		cmd.stale_timeout = (opcode == OP_POLL) && timed_out;
		cmd.pwm_level     = pwm_cnt_next < cmp;
		cmd.compare_value = cmp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			fresh_q   <= 1'b0;
			stale_q   <= '0;
			pwm_cnt_q <= '0;
		end else if (accept) begin
			unique case (opcode)
				OP_CAPTURE: begin
					period_q <= capture_period;
					fresh_q  <= 1'b1;
				end
				OP_POLL: begin
					if (fresh_q) begin
						fresh_q <= 1'b0;
						stale_q <= '0;
					end else begin
						stale_q  <= stale_inc;
						period_q <= period_use;
					end
				end
				OP_TICK: begin
					pwm_cnt_q <= pwm_cnt_next;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/fpt_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_cmdq: two-entry command queue
// Decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module fpt_cmdq (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr,
	input  fpt_pkg::cmd_t  wr_cmd,
	input  wire            rd,
	output fpt_pkg::cmd_t  rd_cmd,
	output logic           q_full,
	output logic           q_empty
);
	import fpt_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rd_cmd  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= !wptr_q;
			end
			if (rd) begin
				rptr_q <= !rptr_q;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/fpt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_back: RPM divider and result register
// Restoring divider, one quotient bit per cycle, feeding a one-beat output.
// ----------------------------------------------------------------------------
module fpt_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_empty,
	input  fpt_pkg::cmd_t                q_cmd,
	output logic                         q_rd,
	input  wire                          pop,
	output logic                         empty,
	output logic [fpt_pkg::RPM_W-1:0]    rpm,
	output logic                         stale_timeout,
	output logic                         pwm_level,
	output logic [fpt_pkg::CMP_W-1:0]    compare_value
);
	import fpt_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [NUM_W-1:0]     quo_q;
	cmd_t                 hold_q;
	logic                 out_valid_q;
	logic [RPM_W-1:0]     rpm_q;
	logic                 timeout_q;
	logic                 pwm_q;
	logic [CMP_W-1:0]     cmp_q;

	logic                 out_free;
	logic [PERIOD_W:0]    shifted;
	logic                 ge;
	logic [PERIOD_W:0]    diff;
	logic [NUM_W-1:0]     quo_next;

	assign out_free = !out_valid_q || pop;
	assign q_rd     = !busy_q && !q_empty && out_free;

	assign shifted  = {rem_q, quo_q[NUM_W-1]};
	assign ge       = shifted >= {1'b0, hold_q.period};
	assign diff     = shifted - {1'b0, hold_q.period};
	assign quo_next = {quo_q[NUM_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (q_rd) begin
			hold_q <= q_cmd;
			rem_q  <= '0;
			quo_q  <= RPM_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
			quo_q <= quo_next;
		end
		if (q_rd && !q_cmd.do_div) begin
			rpm_q     <= '0;
			timeout_q <= q_cmd.stale_timeout;
			pwm_q     <= q_cmd.pwm_level;
			cmp_q     <= q_cmd.compare_value;
		end else if (busy_q && cnt_q == DIV_LAST) begin
			rpm_q     <= quo_next[RPM_W-1:0];
			timeout_q <= hold_q.stale_timeout;
			pwm_q     <= hold_q.pwm_level;
			cmp_q     <= hold_q.compare_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !pop) || (q_rd && !q_cmd.do_div)
			               || (busy_q && cnt_q == DIV_LAST);
			if (q_rd) begin
				cnt_q <= '0;
				if (q_cmd.do_div) begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign empty         = !out_valid_q;
	assign rpm           = rpm_q;
	assign stale_timeout = timeout_q;
	assign pwm_level     = pwm_q;
	assign compare_value = cmp_q;

endmodule
`default_nettype wire

FILE: design/fan_pwm_and_tach_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fan_pwm_and_tach_monitor: fan PWM driver with tachometer monitor
// Path: a push writes the two-entry queue, which loads the result register;
//   a dividing poll first runs 25 divider steps, one per cycle.
// Throughput: one item per cycle without division while results are popped;
//   no new item leaves the queue while the restoring divider is in use.
// Reset: arst_n clears control state, restores register reset values at once.
// ----------------------------------------------------------------------------
module fan_pwm_and_tach_monitor (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push,
	output logic                             full,
	input  wire [fpt_pkg::OPCODE_W-1:0]      opcode,
	input  wire [fpt_pkg::PERIOD_W-1:0]      capture_period,
	output logic                             empty,
	input  wire                              pop,
	output logic [fpt_pkg::RPM_W-1:0]        rpm,
	output logic                             stale_timeout,
	output logic                             pwm_level,
	output logic [fpt_pkg::CMP_W-1:0]        compare_value,
	input  wire                              wr_en,
	input  wire [fpt_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire [fpt_pkg::CFG_DATA_W-1:0]    wr_data
);
	import fpt_pkg::*;

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t q_cmd;
	logic accept;
	logic q_full;
	logic q_empty;
	logic q_rd;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_enable <= 1'b0;
			cfg_q.duty_request <= '0;
			cfg_q.stale_limit  <= STALE_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POWER_ENABLE: cfg_q.power_enable <= wr_data[0];
				REG_DUTY_REQUEST: cfg_q.duty_request <= wr_data;
				REG_STALE_LIMIT:  cfg_q.stale_limit  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	fpt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.opcode         (opcode),
		.capture_period (capture_period),
		.cfg            (cfg_q),
		.cmd            (front_cmd)
	);

	fpt_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_cmd  (front_cmd),
		.rd      (q_rd),
		.rd_cmd  (q_cmd),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	fpt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_cmd         (q_cmd),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.rpm           (rpm),
		.stale_timeout (stale_timeout),
		.pwm_level     (pwm_level),
		.compare_value (compare_value)
	);

endmodule
`default_nettype wire
